### hw/rtl/lscb_pkg.sv
// Shared types, constants and register step functions for the byte stream cipher.
package lscb_pkg;

  localparam int unsigned REG_W       = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SEED_BYTES  = 12;
  localparam int unsigned KEY_LEN_W   = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_KEY_LEN = 12;

  typedef logic [REG_W-1:0]     word_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [KEY_LEN_W-1:0] key_len_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
  } lfsr_state_t;

  // request command codes
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_XFORM   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_A = 2'd0,
    REG_KEY_WORD_B = 2'd1,
    REG_KEY_WORD_C = 2'd2,
    REG_KEY_LENGTH = 2'd3
  } cfg_reg_t;

  localparam key_len_t KEY_LEN_MAX = key_len_t'(MAX_KEY_LEN);

  localparam word_t KEY_WORD_A_RST = 32'd757948787;
  localparam word_t KEY_WORD_B_RST = 32'd1767992947;
  localparam word_t KEY_WORD_C_RST = 32'd1952543277;
  localparam key_len_t KEY_LEN_RST = KEY_LEN_MAX;

  localparam word_t LFSR_A_RST = 32'h13579BDF;
  localparam word_t LFSR_B_RST = 32'h2468ACE0;
  localparam word_t LFSR_C_RST = 32'hFDB97531;

  localparam word_t TAP_A = 32'h80000062;
  localparam word_t SET_A = 32'h80000000;
  localparam word_t CLR_A = 32'h7FFFFFFF;
  localparam word_t TAP_B = 32'h40000020;
  localparam word_t SET_B = 32'hC0000000;
  localparam word_t CLR_B = 32'h3FFFFFFF;
  localparam word_t TAP_C = 32'h10000002;
  localparam word_t SET_C = 32'hF0000000;
  localparam word_t CLR_C = 32'h0FFFFFFF;

  localparam byte_t DEFAULT_SEED [SEED_BYTES] = '{
    8'h43, 8'hC8, 8'h21, 8'hD3, 8'hF4, 8'hB3, 8'h10, 8'h27, 8'h09, 8'hAA, 8'h18, 8'h56
  };

  function automatic word_t step_a(input word_t r);
    return r[0] ? (((r ^ TAP_A) >> 1) | SET_A) : ((r >> 1) & CLR_A);
  endfunction

  function automatic word_t step_b(input word_t r);
    return r[0] ? (((r ^ TAP_B) >> 1) | SET_B) : ((r >> 1) & CLR_B);
  endfunction

  function automatic word_t step_c(input word_t r);
    return r[0] ? (((r ^ TAP_C) >> 1) | SET_C) : ((r >> 1) & CLR_C);
  endfunction

endpackage

### hw/rtl/lscb_ifs.sv
// Handshake channel interfaces: byte requests, results and configuration writes.
interface lscb_in_if;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  lscb_pkg::byte_t      data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface lscb_out_if;
  logic                 valid;
  logic                 ready;
  lscb_pkg::byte_t      out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

interface lscb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lscb_pkg::CFG_IDX_W-1:0]    index;
  lscb_pkg::word_t                   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### hw/rtl/lscb_seed.sv
// Seed builder: expands the key registers into the three shift register seeds.
module lscb_seed (
  input  lscb_pkg::word_t       key_word_a,
  input  lscb_pkg::word_t       key_word_b,
  input  lscb_pkg::word_t       key_word_c,
  input  lscb_pkg::key_len_t    key_length,
  output lscb_pkg::lfsr_state_t seed
);

  localparam int unsigned NB = lscb_pkg::SEED_BYTES;
  localparam int unsigned NL = lscb_pkg::MAX_KEY_LEN + 1;

  logic [3*lscb_pkg::REG_W-1:0] key_flat;
  lscb_pkg::byte_t              key_bytes [NB];
  lscb_pkg::byte_t              cand [NB][NL];
  lscb_pkg::byte_t              sb [NB];
  lscb_pkg::key_len_t           len_sat;
  lscb_pkg::word_t              wa, wb, wc;

  assign key_flat = {key_word_a, key_word_b, key_word_c};
  assign len_sat  = (key_length > lscb_pkg::KEY_LEN_MAX) ? lscb_pkg::KEY_LEN_MAX : key_length;

  for (genvar gi = 0; gi < NB; gi++) begin : g_byte
    localparam int unsigned MSB = 3*lscb_pkg::REG_W - 1 - lscb_pkg::BYTE_W*gi;
    assign key_bytes[gi] = key_flat[MSB -: lscb_pkg::BYTE_W];
    // zero length picks the fixed default seed
    assign cand[gi][0] = lscb_pkg::DEFAULT_SEED[gi];
    for (genvar gl = 1; gl < NL; gl++) begin : g_len
      localparam int unsigned IDX = gi % gl;
      assign cand[gi][gl] = key_bytes[IDX];
    end
    assign sb[gi] = cand[gi][len_sat];
  end

  assign wa = {sb[0], sb[1], sb[2],  sb[3]};
  assign wb = {sb[4], sb[5], sb[6],  sb[7]};
  assign wc = {sb[8], sb[9], sb[10], sb[11]};

  // an all-zero seed would lock the register, so it falls back to the reset value
  assign seed.a = (wa != '0) ? wa : lscb_pkg::LFSR_A_RST;
  assign seed.b = (wb != '0) ? wb : lscb_pkg::LFSR_B_RST;
  assign seed.c = (wc != '0) ? wc : lscb_pkg::LFSR_C_RST;

endmodule

### hw/rtl/lscb_keygen.sv
// Keystream generator: clock-controlled register steps, one per keystream bit, give one keystream byte.
module lscb_keygen (
  input  lscb_pkg::lfsr_state_t cur,
  output lscb_pkg::lfsr_state_t nxt,
  output lscb_pkg::byte_t       ks
);

  always_comb begin
    lscb_pkg::lfsr_state_t s;
    lscb_pkg::byte_t       k;
    logic                  ob;
    logic                  oc;
    s  = cur;
    ob = cur.b[0];
    oc = cur.c[0];
    k  = '0;
    for (int n = 0; n < lscb_pkg::BYTE_W; n++) begin
      // A's low bit before its step decides which of B or C moves
      if (s.a[0]) begin
        ob  = s.b[0];
        s.b = lscb_pkg::step_b(s.b);
      end else begin
        oc  = s.c[0];
        s.c = lscb_pkg::step_c(s.c);
      end
      s.a = lscb_pkg::step_a(s.a);
      k   = {k[lscb_pkg::BYTE_W-2:0], ob ^ oc};
    end
    nxt = s;
    ks  = k;
  end

endmodule

### hw/rtl/lfsr_stream_cipher_byte.sv
// Top level: request register, shift register state, keystream logic and result register.
// Path: a byte request passes through the request register, then the result register,
//   and is held back while the result side stalls.
// Throughput: one request per cycle while the result side does not stall; a restart uses one
// slot and gives no result. Eight-step keystream logic lies between state and result registers.
// Reset (rst, synchronous): valids clear, key registers and shift registers take their defaults.
module lfsr_stream_cipher_byte (
  input  logic          clk,
  input  logic          rst,
  lscb_cfg_if.sink      cfg,
  lscb_in_if.sink       req,
  lscb_out_if.source    res
);

  lscb_pkg::word_t       key_word_a;
  lscb_pkg::word_t       key_word_b;
  lscb_pkg::word_t       key_word_c;
  lscb_pkg::key_len_t    key_length;

  lscb_pkg::lfsr_state_t lfsr;
  lscb_pkg::lfsr_state_t lfsr_next;
  lscb_pkg::lfsr_state_t seed;
  lscb_pkg::byte_t       ks;
  lscb_pkg::byte_t       xored;

  logic                  s1_valid;
  logic                  s1_cmd;
  lscb_pkg::byte_t       s1_data;
  logic                  out_valid;
  lscb_pkg::byte_t       out_byte;
  logic                  advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_a <= lscb_pkg::KEY_WORD_A_RST;
      key_word_b <= lscb_pkg::KEY_WORD_B_RST;
      key_word_c <= lscb_pkg::KEY_WORD_C_RST;
      key_length <= lscb_pkg::KEY_LEN_RST;
    end else if (cfg.valid) begin
      case (lscb_pkg::cfg_reg_t'(cfg.index))
        lscb_pkg::REG_KEY_WORD_A: key_word_a <= cfg.wdata;
        lscb_pkg::REG_KEY_WORD_B: key_word_b <= cfg.wdata;
        lscb_pkg::REG_KEY_WORD_C: key_word_c <= cfg.wdata;
        lscb_pkg::REG_KEY_LENGTH: key_length <= cfg.wdata[lscb_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  lscb_seed u_seed (
    .key_word_a (key_word_a),
    .key_word_b (key_word_b),
    .key_word_c (key_word_c),
    .key_length (key_length),
    .seed       (seed)
  );

  lscb_keygen u_keygen (
    .cur (lfsr),
    .nxt (lfsr_next),
    .ks  (ks)
  );

  // restarts never wait on the result side
  assign advance   = s1_valid && ((s1_cmd == lscb_pkg::CMD_RESTART) || !out_valid || res.ready);
  assign req.ready = !s1_valid || advance;
  assign xored     = s1_data ^ ks;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_cmd  <= req.cmd;
      s1_data <= req.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr.a <= lscb_pkg::LFSR_A_RST;
      lfsr.b <= lscb_pkg::LFSR_B_RST;
      lfsr.c <= lscb_pkg::LFSR_C_RST;
    end else if (advance) begin
      lfsr <= (s1_cmd == lscb_pkg::CMD_RESTART) ? seed : lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (s1_cmd == lscb_pkg::CMD_XFORM)) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (s1_cmd == lscb_pkg::CMD_XFORM)) begin
      // a zero XOR passes the data byte through
      out_byte <= (xored != '0) ? xored : s1_data;
    end
  end

  assign res.valid    = out_valid;
  assign res.out_byte = out_byte;

`ifndef ASSERT_OFF
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(lfsr))
    else $error("shift register state moved without a request");

  a_taken_request_held: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> s1_valid)
    else $error("accepted request lost before processing");

  a_xform_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_cmd == lscb_pkg::CMD_XFORM)) |=> out_valid)
    else $error("byte request produced no result");

  a_restart_no_result: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_cmd == lscb_pkg::CMD_RESTART))
      |=> (out_valid == ($past(out_valid) && !$past(res.ready))))
    else $error("restart request produced a result");
`endif

endmodule
